// ===== rtl/core/u8dec_pkg.sv =====
// Types, constants and the per-byte decode step for the UTF-8 byte stream decoder.
// Self-contained; used by utf8_byte_stream_decoder_top.
package u8dec_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 23;
  localparam int unsigned PEND_W  = 2;

  localparam logic [BYTE_W-1:0] LEAD3_PREFIX = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD2_PREFIX = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD1_PREFIX = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_MARK    = 8'h80;
  localparam logic [CP_W-1:0]   REPLACEMENT  = 23'h00FFFD;

  localparam logic [PEND_W-1:0] PEND_IDLE = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
  localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

  typedef struct packed {
    logic              emit;
    logic              malformed;
    logic [CP_W-1:0]   code_point;
    logic [PEND_W-1:0] pending;
    logic [CP_W-1:0]   partial;
  } step_t;

  // One byte through the decoder: next state plus an optional result.
  function automatic step_t decode_step(input logic [BYTE_W-1:0] b,
                                        input logic [PEND_W-1:0] pend,
                                        input logic [CP_W-1:0]   part);
    step_t             r;
    logic [BYTE_W-1:0] lp;
    logic [PEND_W-1:0] np;
    logic [CP_W-1:0]   pay;
    logic [CP_W-1:0]   sum;
    r   = '0;
    lp  = '0;
    np  = PEND_IDLE;
    pay = '0;
    sum = '0;
    if (pend == PEND_IDLE) begin
      if ((b & LEAD3_PREFIX) == LEAD3_PREFIX) begin
        lp        = b ^ LEAD3_PREFIX;
        r.pending = PEND_THREE;
        r.partial = {1'b0, lp[3:0], 18'b0};
      end else if ((b & LEAD2_PREFIX) == LEAD2_PREFIX) begin
        lp        = b ^ LEAD2_PREFIX;
        r.pending = PEND_TWO;
        r.partial = {6'b0, lp[4:0], 12'b0};
      end else if ((b & LEAD1_PREFIX) == LEAD1_PREFIX) begin
        lp        = b ^ LEAD1_PREFIX;
        r.pending = PEND_ONE;
        r.partial = {11'b0, lp[5:0], 6'b0};
      end else begin
        // single byte, terminator included
        r.emit       = 1'b1;
        r.code_point = {{(CP_W-BYTE_W){1'b0}}, b};
      end
    end else if ((b & CONT_MARK) == '0) begin
      // missing continuation: drop the byte, flag, return to idle
      r.emit       = 1'b1;
      r.malformed  = 1'b1;
      r.code_point = REPLACEMENT;
    end else begin
      lp = b ^ CONT_MARK;
      np = pend - PEND_ONE;
      case (np)
        PEND_IDLE: pay = {16'b0, lp[6:0]};
        PEND_ONE:  pay = {10'b0, lp[6:0], 6'b0};
        default:   pay = {4'b0, lp[6:0], 12'b0};
      endcase
      sum = part + pay;
      if (np == PEND_IDLE) begin
        r.emit       = 1'b1;
        r.code_point = sum;
      end else begin
        r.pending = np;
        r.partial = sum;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/utf8_byte_stream_decoder_top.sv =====
// UTF-8 byte stream decoder: one byte in per item, zero or one code point out.
// Depends on u8dec_pkg for constants and the decode step.
//
// Usage:
//   Input channel (in_valid/in_ready, byte_in) carries one raw byte per item.
//   Output channel (out_valid/out_ready, code_point, malformed) carries one
//   decoded code point per item. A lead byte of a multi-byte sequence and
//   each inner continuation byte give no output item.
//   A zero byte while idle gives code point 0 as end-of-string marker.
//   A continuation slot without bit 7 gives FFFD with malformed set; that
//   byte is dropped and decoding restarts at the next byte.
// Timing:
//   An accepted byte lands in the input register; the decode step runs
//   combinationally on it, and its result lands in the output register
//   once the output register is free or its result is being taken.
//   One byte per cycle is accepted for as long as results are taken; the
//   combinational decode path from input register to output register sets it.
// Reset and stall:
//   rst (synchronous) empties both registers and returns decoding to idle.
//   While out_ready is low the result holds; the input register fills and
//   in_ready drops only when both registers are occupied.
module utf8_byte_stream_decoder_top
  import u8dec_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] byte_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CP_W-1:0]   code_point,
  output logic              malformed
);

  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic [PEND_W-1:0] bytes_pending;
  logic [CP_W-1:0]   partial_value;
  logic              advance;
  step_t             step;

  // Drain the input register whenever the output slot is free or leaving.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;
  assign step     = decode_step(in_byte, bytes_pending, partial_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_byte <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= PEND_IDLE;
      partial_value <= '0;
    end else if (advance) begin
      bytes_pending <= step.pending;
      partial_value <= step.partial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && step.emit) begin
      code_point <= step.code_point;
      malformed  <= step.malformed;
    end
  end

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    bytes_pending == PEND_IDLE |-> partial_value == '0)
    else $error("partial value left over while idle");

  a_bad_is_repl: assert property (@(posedge clk) disable iff (rst)
    out_valid && malformed |-> code_point == REPLACEMENT)
    else $error("malformed result without replacement code point");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

// ===== sim/tb_utf8_byte_stream_decoder_top.sv =====
`timescale 1ns / 100ps
// Testbench for utf8_byte_stream_decoder_top: random bytes and UTF-8 sequences in,
// decoded code points checked against an in-bench decoder. Depends on u8dec_pkg.
module tb_utf8_byte_stream_decoder_top;
  import u8dec_pkg::*;

  localparam int unsigned PAY_SHIFT   = 6;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 650;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            bad;
  } decoded_t;

  // Decodes the accepted bytes on its own and holds the code points still owed.
  class code_point_ledger;
    logic [PEND_W-1:0] seq_left;
    logic [CP_W-1:0]   seq_value;
    decoded_t          owed[$];
    int                errors;

    function new();
      seq_left  = PEND_IDLE;
      seq_value = '0;
      errors    = 0;
    endfunction

    function void owe(logic [CP_W-1:0] cp, logic bad);
      decoded_t d;
      d.cp  = cp;
      d.bad = bad;
      owed.push_back(d);
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      if (seq_left == PEND_IDLE) begin
        if ((b & LEAD3_PREFIX) == LEAD3_PREFIX) begin
          seq_left  = PEND_THREE;
          seq_value = CP_W'(b ^ LEAD3_PREFIX) << (3 * PAY_SHIFT);
        end else if ((b & LEAD2_PREFIX) == LEAD2_PREFIX) begin
          seq_left  = PEND_TWO;
          seq_value = CP_W'(b ^ LEAD2_PREFIX) << (2 * PAY_SHIFT);
        end else if ((b & LEAD1_PREFIX) == LEAD1_PREFIX) begin
          seq_left  = PEND_ONE;
          seq_value = CP_W'(b ^ LEAD1_PREFIX) << PAY_SHIFT;
        end else begin
          owe(CP_W'(b), 1'b0);
        end
      end else if ((b & CONT_MARK) == '0) begin
        // drop the byte and restart
        seq_left  = PEND_IDLE;
        seq_value = '0;
        owe(REPLACEMENT, 1'b1);
      end else begin
        seq_left  = seq_left - PEND_ONE;
        seq_value = seq_value + (CP_W'(b ^ CONT_MARK) << (seq_left * PAY_SHIFT));
        if (seq_left == PEND_IDLE) begin
          owe(seq_value, 1'b0);
          seq_value = '0;
        end
      end
    endfunction

    function void match_code_point(logic [CP_W-1:0] cp, logic bad);
      decoded_t d;
      if (owed.size() == 0) begin
        $error("unexpected result: code_point %h malformed %b", cp, bad);
        errors++;
        return;
      end
      d = owed.pop_front();
      if (cp !== d.cp) begin
        $error("code_point: expected %h, actual %h", d.cp, cp);
        errors++;
      end
      if (bad !== d.bad) begin
        $error("malformed: expected %b, actual %b", d.bad, bad);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] byte_in;
  logic              out_valid;
  logic              out_ready;
  logic [CP_W-1:0]   code_point;
  logic              malformed;

  code_point_ledger ledger;
  logic             calm;
  int               n_bytes;
  int               quiet_cycles;

  utf8_byte_stream_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .byte_in   (byte_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_point(code_point),
    .malformed (malformed)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    ledger       = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    byte_in      = '0;
    out_ready    = 1'b0;
    calm         = 1'b0;
    n_bytes      = 0;
    quiet_cycles = 0;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) ledger.take_byte(byte_in);
      if (out_valid && out_ready) ledger.match_code_point(code_point, malformed);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_bytes++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (ledger.owed.size() != 0) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_lead(int len);
    case (len)
      1:       return BYTE_W'($urandom_range(0, 8'hBF));
      2:       return BYTE_W'($urandom_range(8'hC0, 8'hDF));
      3:       return BYTE_W'($urandom_range(8'hE0, 8'hEF));
      default: return BYTE_W'($urandom_range(8'hF0, 8'hFF));
    endcase
  endfunction

  // mostly 10xxxxxx, now and then 11xxxxxx, which still counts as a continuation
  function automatic logic [BYTE_W-1:0] pick_cont();
    if ($urandom_range(99) < 85) return BYTE_W'($urandom_range(8'h80, 8'hBF));
    return BYTE_W'($urandom_range(8'hC0, 8'hFF));
  endfunction

  initial begin
    int  kind;
    int  len;
    int  cut;
    int  k;
    int  target;
    bit  paused;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // single bytes: terminator, ASCII top, lone continuation values
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'hBF);
    // smallest and largest of each sequence length
    send_byte(8'hC0); send_byte(8'h80);
    send_byte(8'hDF); send_byte(8'hBF);
    send_byte(8'hE0); send_byte(8'h80); send_byte(8'h80);
    send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);
    send_byte(8'hF0); send_byte(8'h80); send_byte(8'h80); send_byte(8'h80);
    // F8..FF lead like F0
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
    // missing continuation, then zero mid-sequence
    send_byte(8'hC5); send_byte(8'h41);
    send_byte(8'hE2); send_byte(8'h82); send_byte(8'h00);

    target = n_bytes + RANDOM_ITEMS;
    while (n_bytes < target) begin
      if (!paused && n_bytes > target - 350) begin
        // hold the sender until every owed result is out
        in_valid <= 1'b0;
        wait_drained();
        paused = 1'b1;
      end
      calm = (n_bytes > target - 230) && (n_bytes < target - 90);
      kind = $urandom_range(99);
      if (kind < 70) begin
        len = $urandom_range(1, 4);
        send_byte(pick_lead(len));
        for (k = 1; k < len; k++) send_byte(pick_cont());
      end else if (kind < 85) begin
        len = $urandom_range(2, 4);
        cut = $urandom_range(0, len - 2);
        send_byte(pick_lead(len));
        for (k = 0; k < cut; k++) send_byte(pick_cont());
        send_byte(BYTE_W'($urandom_range(0, 8'h7F)));
      end else begin
        send_byte(BYTE_W'($urandom_range(0, 8'hFF)));
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (ledger.owed.size() != 0) begin
      $error("%0d expected results never arrived", ledger.owed.size());
      ledger.errors++;
    end
    if (ledger.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
